FILE: design/ppp_pkg.sv
// Shared types and constants for the pinhole point projector.
`timescale 1ns / 1ps
package ppp_pkg;
    localparam int CoordW   = 32;
    localparam int CoefW    = 32;
    localparam int PairW    = 64;
    localparam int NumPairs = 6;
    localparam int IdxW     = 3;
    localparam int SumW     = 49;
    localparam int MagW     = 48;
    localparam int QuotW    = 32;

    localparam logic [PairW-1:0] PairReset0 = 64'h0001_0000_0000_0000;
    localparam logic [PairW-1:0] PairReset1 = 64'h0;
    localparam logic [PairW-1:0] PairReset2 = 64'h0000_0000_0001_0000;
    localparam logic [PairW-1:0] PairReset3 = 64'h0;
    localparam logic [PairW-1:0] PairReset4 = 64'h0;
    localparam logic [PairW-1:0] PairReset5 = 64'h0001_0000_0000_0000;

    localparam logic [QuotW-1:0] PosLimit = 32'h7FFF_FFFF;
    localparam logic [QuotW-1:0] NegLimit = 32'h8000_0000;

    // One divider lane as it moves from cell to cell.
    typedef struct packed {
        logic [MagW-1:0]  rem;
        logic [QuotW-1:0] low;
        logic [QuotW-1:0] quot;
    } lane_t;

    // Per-item control that travels beside the divider lanes.
    typedef struct packed {
        logic [MagW-1:0] den;
        logic            neg_u;
        logic            neg_v;
        logic            ovf_u;
        logic            ovf_v;
        logic            zero;
    } side_t;
endpackage

FILE: design/ppp_if.sv
// Channel interfaces for points in and projected coordinates out.
`timescale 1ns / 1ps
interface ppp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface ppp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] img_u;
    logic signed [31:0] img_v;
    logic               depth_zero;
    logic               clipped;
    modport source (output valid, img_u, img_v, depth_zero, clipped, input ready);
    modport sink   (input valid, img_u, img_v, depth_zero, clipped, output ready);
endinterface

FILE: design/ppp_dot.sv
// One matrix row dotted with [x y z 1]: multiply stage, then floor and sum stage.
`timescale 1ns / 1ps
module ppp_dot (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [ppp_pkg::CoefW-1:0]  c0,
    input  logic signed [ppp_pkg::CoefW-1:0]  c1,
    input  logic signed [ppp_pkg::CoefW-1:0]  c2,
    input  logic signed [ppp_pkg::CoefW-1:0]  c3,
    input  logic signed [ppp_pkg::CoordW-1:0] x,
    input  logic signed [ppp_pkg::CoordW-1:0] y,
    input  logic signed [ppp_pkg::CoordW-1:0] z,
    output logic signed [ppp_pkg::SumW-1:0]   sum
);
    import ppp_pkg::*;

    logic signed [63:0]      px_reg, py_reg, pz_reg;
    logic signed [CoefW-1:0] t_reg;
    logic signed [47:0]      fx, fy, fz;
    logic signed [SumW-1:0]  sum_next, sum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= c0 * x;
            py_reg  <= c1 * y;
            pz_reg  <= c2 * z;
            t_reg   <= c3;
            sum_reg <= sum_next;
        end
    end

    // Arithmetic shift floors each Q32.32 product to Q16.16.
    always_comb
    begin
        fx = 48'(px_reg >>> 16);
        fy = 48'(py_reg >>> 16);
        fz = 48'(pz_reg >>> 16);
        sum_next = SumW'(fx) + SumW'(fy) + SumW'(fz) + SumW'(t_reg);
    end

    assign sum = sum_reg;
endmodule

FILE: design/ppp_div_cell.sv
// One restoring division step: brings down a dividend bit and makes one quotient bit.
`timescale 1ns / 1ps
module ppp_div_cell (
    input  logic                       clk,
    input  logic                       en,
    input  logic [ppp_pkg::MagW-1:0]   den,
    input  ppp_pkg::lane_t             lane_in,
    output ppp_pkg::lane_t             lane_out
);
    import ppp_pkg::*;

    logic [MagW:0] shifted;
    logic          fits;
    lane_t         lane_next, lane_reg;

    always_comb
    begin
        shifted = {lane_in.rem, lane_in.low[QuotW-1]};
        fits    = shifted >= {1'b0, den};
        lane_next.rem  = fits ? MagW'(shifted - {1'b0, den}) : shifted[MagW-1:0];
        lane_next.low  = {lane_in.low[QuotW-2:0], 1'b0};
        lane_next.quot = {lane_in.quot[QuotW-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;
endmodule

FILE: design/pinhole_point_projector.sv
// Top level of the pinhole point projector: matrix rows, divider chain, saturation.
// Pipeline: dot multiply, dot sum, setup, the divide cells, then the output register.
// Throughput: one point per cycle while the output is not stalled; the 32-cell divider chain
// is fully pipelined. A stalled output freezes the whole pipeline in place.
// Reset: asynchronous, active low; clears all valid bits and loads the identity-like
// default camera matrix.
`timescale 1ns / 1ps
module pinhole_point_projector (
    input  logic                         clk,
    input  logic                         rst_n,
    ppp_in_if.sink                       in_ch,
    ppp_out_if.source                    out_ch,
    input  logic                         cfg_we,
    input  logic [ppp_pkg::IdxW-1:0]     cfg_index,
    input  logic [ppp_pkg::PairW-1:0]    cfg_data
);
    import ppp_pkg::*;

    localparam int Stages = QuotW;

    // Configuration: six coefficient pairs, upper half is the even column.
    logic [PairW-1:0] pair_reg [NumPairs];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg[0] <= PairReset0;
            pair_reg[1] <= PairReset1;
            pair_reg[2] <= PairReset2;
            pair_reg[3] <= PairReset3;
            pair_reg[4] <= PairReset4;
            pair_reg[5] <= PairReset5;
        end
        else if (cfg_we && (int'(cfg_index) < NumPairs))
        begin
            pair_reg[cfg_index] <= cfg_data;
        end
    end

    // The whole pipeline advances together unless a finished result is held.
    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    logic vld_dot1_reg, vld_dot2_reg;
    logic [Stages:0] vld_chain_reg;

    // Three row units; each has a multiply stage and a floor and sum stage.
    logic signed [SumW-1:0] up_sum, vp_sum, w_sum;

    ppp_dot u_row0 (
        .clk (clk), .en (en),
        .c0  (pair_reg[0][63:32]), .c1 (pair_reg[0][31:0]),
        .c2  (pair_reg[1][63:32]), .c3 (pair_reg[1][31:0]),
        .x   (in_ch.pos_x), .y (in_ch.pos_y), .z (in_ch.pos_z),
        .sum (up_sum)
    );
    ppp_dot u_row1 (
        .clk (clk), .en (en),
        .c0  (pair_reg[2][63:32]), .c1 (pair_reg[2][31:0]),
        .c2  (pair_reg[3][63:32]), .c3 (pair_reg[3][31:0]),
        .x   (in_ch.pos_x), .y (in_ch.pos_y), .z (in_ch.pos_z),
        .sum (vp_sum)
    );
    ppp_dot u_row2 (
        .clk (clk), .en (en),
        .c0  (pair_reg[4][63:32]), .c1 (pair_reg[4][31:0]),
        .c2  (pair_reg[5][63:32]), .c3 (pair_reg[5][31:0]),
        .x   (in_ch.pos_x), .y (in_ch.pos_y), .z (in_ch.pos_z),
        .sum (w_sum)
    );

    // Setup: take magnitudes and signs. When |num| >= |w| * 2^16 the integer
    // part does not fit and the quotient saturates; otherwise the quotient
    // fits 32 bits and the starting remainder is below the divisor.
    logic [MagW-1:0] mag_u, mag_v, mag_w;
    lane_t           lane_u_next, lane_v_next;
    side_t           side_next;

    always_comb
    begin
        mag_u = up_sum[SumW-1] ? MagW'(-up_sum) : up_sum[MagW-1:0];
        mag_v = vp_sum[SumW-1] ? MagW'(-vp_sum) : vp_sum[MagW-1:0];
        mag_w = w_sum[SumW-1]  ? MagW'(-w_sum)  : w_sum[MagW-1:0];

        lane_u_next.rem  = MagW'(mag_u[MagW-1:16]);
        lane_u_next.low  = {mag_u[15:0], 16'h0};
        lane_u_next.quot = '0;
        lane_v_next.rem  = MagW'(mag_v[MagW-1:16]);
        lane_v_next.low  = {mag_v[15:0], 16'h0};
        lane_v_next.quot = '0;

        side_next.den   = mag_w;
        side_next.neg_u = up_sum[SumW-1] != w_sum[SumW-1];
        side_next.neg_v = vp_sum[SumW-1] != w_sum[SumW-1];
        side_next.ovf_u = MagW'(mag_u[MagW-1:16]) >= mag_w;
        side_next.ovf_v = MagW'(mag_v[MagW-1:16]) >= mag_w;
        side_next.zero  = (w_sum == '0);
    end

    lane_t lane_u [Stages+1];
    lane_t lane_v [Stages+1];
    side_t side_reg [Stages+1];
    lane_t lane_u0_reg, lane_v0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_u0_reg <= lane_u_next;
            lane_v0_reg <= lane_v_next;
            side_reg[0] <= side_next;
        end
    end

    assign lane_u[0] = lane_u0_reg;
    assign lane_v[0] = lane_v0_reg;

    // The divider chain: each stage has one cell per lane and its side data.
    for (genvar k = 0; k < Stages; k++)
    begin : g_div
        ppp_div_cell u_cell_u (
            .clk (clk), .en (en), .den (side_reg[k].den),
            .lane_in (lane_u[k]), .lane_out (lane_u[k+1])
        );
        ppp_div_cell u_cell_v (
            .clk (clk), .en (en), .den (side_reg[k].den),
            .lane_in (lane_v[k]), .lane_out (lane_v[k+1])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_dot1_reg  <= 1'b0;
            vld_dot2_reg  <= 1'b0;
            vld_chain_reg <= '0;
        end
        else if (en)
        begin
            vld_dot1_reg  <= in_ch.valid;
            vld_dot2_reg  <= vld_dot1_reg;
            vld_chain_reg <= {vld_chain_reg[Stages-1:0], vld_dot2_reg};
        end
    end

    // Saturation and sign, then the output register.
    side_t            side_end;
    logic [QuotW-1:0] lim_u, lim_v;
    logic             clip_u, clip_v;
    logic [QuotW-1:0] mag_qu, mag_qv;
    logic signed [31:0] u_next, v_next, u_reg, v_reg;
    logic             zero_next, clip_next, zero_reg, clip_reg;

    always_comb
    begin
        side_end = side_reg[Stages];
        lim_u  = side_end.neg_u ? NegLimit : PosLimit;
        lim_v  = side_end.neg_v ? NegLimit : PosLimit;
        clip_u = side_end.ovf_u || (lane_u[Stages].quot > lim_u);
        clip_v = side_end.ovf_v || (lane_v[Stages].quot > lim_v);
        mag_qu = clip_u ? lim_u : lane_u[Stages].quot;
        mag_qv = clip_v ? lim_v : lane_v[Stages].quot;
        zero_next = side_end.zero;
        if (side_end.zero)
        begin
            u_next    = '0;
            v_next    = '0;
            clip_next = 1'b0;
        end
        else
        begin
            u_next    = side_end.neg_u ? -$signed(mag_qu) : $signed(mag_qu);
            v_next    = side_end.neg_v ? -$signed(mag_qv) : $signed(mag_qv);
            clip_next = clip_u || clip_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_chain_reg[Stages];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= u_next;
            v_reg    <= v_next;
            zero_reg <= zero_next;
            clip_reg <= clip_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.img_u      = u_reg;
    assign out_ch.img_v      = v_reg;
    assign out_ch.depth_zero = zero_reg;
    assign out_ch.clipped    = clip_reg;
endmodule

FILE: design/ppp_checker.sv
// Port-level checks for the pinhole point projector, bound to the top level.
`timescale 1ns / 1ps
module ppp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] img_u,
    input logic [31:0] img_v,
    input logic        depth_zero,
    input logic        clipped
);
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && depth_zero |-> img_u == 32'h0 && img_v == 32'h0 && !clipped)
        else $error("zero depth result not cleared");

    a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |->
            img_u == 32'h7FFF_FFFF || img_u == 32'h8000_0000 ||
            img_v == 32'h7FFF_FFFF || img_v == 32'h8000_0000)
        else $error("clipped result is not at a limit");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(img_u) && $stable(img_v))
        else $error("stalled result changed");

    a_u_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && depth_zero |-> !clipped)
        else $error("zero depth and clipped together");
endmodule

bind pinhole_point_projector ppp_checker u_ppp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .img_u      (out_ch.img_u),
    .img_v      (out_ch.img_v),
    .depth_zero (out_ch.depth_zero),
    .clipped    (out_ch.clipped)
);

FILE: sim/tb_pinhole_point_projector.sv
// Self-checking testbench for the pinhole point projector: directed and random points through several camera matrices.
`timescale 1ns / 1ps
module tb_pinhole_point_projector;
    import ppp_pkg::*;

    // Register indexes of the camera matrix, two coefficients per register.
    typedef enum logic [IdxW-1:0] {
        RegRow0Lo = 3'd0,
        RegRow0Hi = 3'd1,
        RegRow1Lo = 3'd2,
        RegRow1Hi = 3'd3,
        RegRow2Lo = 3'd4,
        RegRow2Hi = 3'd5,
        RegBad6   = 3'd6,
        RegBad7   = 3'd7
    } coef_reg_e;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    typedef struct {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic               dz;
        logic               clip;
    } pixel_t;

    localparam int Latency    = 36;
    localparam int StallLimit = 20000;
    localparam int LongStall  = 300;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IdxW-1:0] cfg_index;
    logic [PairW-1:0] cfg_data;

    ppp_in_if  in_ch();
    ppp_out_if out_ch();

    pinhole_point_projector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The testbench's own copy of the camera matrix registers.
    logic [PairW-1:0] cam_pair [NumPairs];

    point_t point_queue[$];
    pixel_t pixel_queue[$];
    int     fail_count;
    int     idle_cycles;
    int     hold_off;        // cycles the receiver must still refuse
    int     in_gap;          // cycles the sender must still stay idle
    bit     sender_pause;    // sender waits for the pipeline to drain
    bit     long_stall_req;  // asks the receiver for one long hold-off
    bit     long_stall_done;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Coefficient at row r and column c, sign extended.
    function automatic logic signed [63:0] cam_coef(int r, int c);
        logic [PairW-1:0] p;
        p = cam_pair[r * 2 + c / 2];
        return (c % 2) ? {{32{p[31]}}, p[31:0]} : {{32{p[63]}}, p[63:32]};
    endfunction

    // One row of the matrix applied to [x y z 1]; each product floored to Q16.16.
    function automatic logic signed [63:0] row_sum(int r, point_t pt);
        logic signed [63:0] px, py, pz;
        px = cam_coef(r, 0) * 64'(pt.x);
        py = cam_coef(r, 1) * 64'(pt.y);
        pz = cam_coef(r, 2) * 64'(pt.z);
        return (px >>> 16) + (py >>> 16) + (pz >>> 16) + cam_coef(r, 3);
    endfunction

    // Signed Q16.16 quotient truncated toward zero, saturated to 32 bits.
    function automatic logic signed [31:0] sat_divide(logic signed [63:0] num,
                                                      logic signed [63:0] den,
                                                      inout logic clip);
        logic        neg;
        logic [63:0] a, b, ip, rem, lim, q;
        neg = (num < 0) != (den < 0);
        a   = (num < 0) ? -num : num;
        b   = (den < 0) ? -den : den;
        ip  = a / b;
        rem = a % b;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (ip >= 64'h1_0000)
            q = lim + 1;
        else
            q = (ip << 16) + ((rem << 16) / b);
        if (q > lim)
        begin
            q    = lim;
            clip = 1'b1;
        end
        if (neg)
            q = -q;
        return q[31:0];
    endfunction

    function automatic pixel_t project_point(point_t pt);
        pixel_t px;
        logic signed [63:0] up, vp, w;
        up = row_sum(0, pt);
        vp = row_sum(1, pt);
        w  = row_sum(2, pt);
        px.u    = '0;
        px.v    = '0;
        px.dz   = 1'b0;
        px.clip = 1'b0;
        if (w == 0)
            px.dz = 1'b1;
        else
        begin
            px.u = sat_divide(up, w, px.clip);
            px.v = sat_divide(vp, w, px.clip);
        end
        return px;
    endfunction

    // Driver: offers points from the pending queue and records the expected
    // pixel at each accepted transfer. The head of the queue is always the
    // point on the bus.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.pos_x <= '0;
            in_ch.pos_y <= '0;
            in_ch.pos_z <= '0;
            in_gap      <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                point_t pt;
                pt.x = in_ch.pos_x;
                pt.y = in_ch.pos_y;
                pt.z = in_ch.pos_z;
                pixel_queue = {pixel_queue, project_point(pt)};
                void'(point_queue.pop_front());
            end
            // Decide the next offer once the current one is settled.
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap      <= in_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (point_queue.size() != 0 && !sender_pause &&
                         $urandom_range(0, 3) != 0)
                begin
                    point_t nx;
                    nx = point_queue[0];
                    in_ch.valid <= 1'b1;
                    in_ch.pos_x <= nx.x;
                    in_ch.pos_y <= nx.y;
                    in_ch.pos_z <= nx.z;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                    // Now and then the sender goes quiet for a longer while.
                    if ($urandom_range(0, 15) == 0)
                        in_gap <= $urandom_range(8, 40);
                end
            end
        end
    end

    // Monitor: randomly stalls the output and compares every transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pixel_queue.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    pixel_t ex;
                    ex = pixel_queue.pop_front();
                    if (out_ch.img_u !== ex.u)
                    begin
                        $error("img_u expected %0d actual %0d", ex.u, out_ch.img_u);
                        fail_count++;
                    end
                    if (out_ch.img_v !== ex.v)
                    begin
                        $error("img_v expected %0d actual %0d", ex.v, out_ch.img_v);
                        fail_count++;
                    end
                    if (out_ch.depth_zero !== ex.dz)
                    begin
                        $error("depth_zero expected %0b actual %0b", ex.dz,
                               out_ch.depth_zero);
                        fail_count++;
                    end
                    if (out_ch.clipped !== ex.clip)
                    begin
                        $error("clipped expected %0b actual %0b", ex.clip,
                               out_ch.clipped);
                        fail_count++;
                    end
                end
            end
            // A running hold-off takes priority, then a requested long one;
            // otherwise mostly ready, with occasional short or long stalls.
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_ch.ready <= 1'b0;
            end
            else if (long_stall_req && !long_stall_done)
            begin
                long_stall_done <= 1'b1;
                hold_off        <= LongStall;
                out_ch.ready    <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 70)
                out_ch.ready <= 1'b1;
            else if ($urandom_range(0, 19) == 0)
                hold_off <= $urandom_range(10, 60);
            else
                out_ch.ready <= 1'b0;
        end
    end

    // Watchdog: counts cycles without any transfer and fails the run past StallLimit.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(coef_reg_e idx, logic [PairW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx < NumPairs)
            cam_pair[idx] = val;
    endtask

    task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        point_t pt;
        pt.x = x;
        pt.y = y;
        pt.z = z;
        point_queue = {point_queue, pt};
    endtask

    // Waits until every point is sent and every pixel has arrived, then lets
    // the pipeline settle before the matrix changes.
    task automatic drain();
        while (point_queue.size() != 0 || in_ch.valid || pixel_queue.size() != 0)
            @(posedge clk);
        repeat (Latency + 5) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
            default: return 32'($signed($urandom_range(0, 32'h0020_0000))
                                - 32'sh0010_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'h0;
            default: return 32'($signed($urandom_range(0, 32'h0008_0000))
                                - 32'sh0004_0000);
        endcase
    endfunction

    task automatic random_points(int n);
        repeat (n) add_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    initial
    begin
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        fail_count     = 0;
        idle_cycles    = 0;
        hold_off       = 0;
        sender_pause   = 1'b0;
        long_stall_req = 1'b0;
        cam_pair[0]    = PairReset0;
        cam_pair[1]    = PairReset1;
        cam_pair[2]    = PairReset2;
        cam_pair[3]    = PairReset3;
        cam_pair[4]    = PairReset4;
        cam_pair[5]    = PairReset5;
        rst_n          = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points with the reset matrix (u = x/z, v = y/z).
        add_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        add_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);   // zero depth
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);   // clipped both ways
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        add_point(32'h0003_0000, 32'hFFFD_0000, 32'h0007_0000);   // truncation
        add_point(32'hFFFF_0000, 32'h0000_8000, 32'h0000_0002);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000);
        drain();

        // Every register, including the two ignored indexes above the last pair.
        write_reg(RegRow0Lo, {32'h0200_0000, 32'h0000_8000});
        write_reg(RegRow0Hi, {32'hFFFF_0000, 32'h0010_0000});
        write_reg(RegRow1Lo, {32'h0000_0000, 32'h0200_0000});
        write_reg(RegRow1Hi, {32'h0000_4000, 32'hFFF0_0000});
        write_reg(RegRow2Lo, {32'h0000_1000, 32'hFFFF_F000});
        write_reg(RegRow2Hi, {32'h0001_0000, 32'h0000_0000});
        write_reg(RegBad6, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(RegBad7, 64'h1234_5678_9ABC_DEF0);
        add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);  // w from translation = 0
        add_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
        random_points(100);
        // Receiver holds off long while the sender keeps offering.
        long_stall_req = 1'b1;
        random_points(60);
        drain();

        // Extreme coefficients.
        write_reg(RegRow0Lo, 64'h7FFF_FFFF_8000_0000);
        write_reg(RegRow0Hi, 64'h8000_0000_7FFF_FFFF);
        write_reg(RegRow1Lo, 64'h8000_0000_8000_0000);
        write_reg(RegRow1Hi, 64'h7FFF_FFFF_7FFF_FFFF);
        write_reg(RegRow2Lo, 64'h7FFF_FFFF_7FFF_FFFF);
        write_reg(RegRow2Hi, 64'h8000_0000_0000_0001);
        random_points(60);
        // Sender pauses midway until every expected pixel has arrived.
        while (point_queue.size() > 30) @(posedge clk);
        sender_pause = 1'b1;
        while (in_ch.valid || pixel_queue.size() != 0) @(posedge clk);
        sender_pause = 1'b0;
        drain();

        // Random matrices.
        repeat (3)
        begin
            write_reg(RegRow0Lo, {rand_coef(), rand_coef()});
            write_reg(RegRow0Hi, {rand_coef(), rand_coef()});
            write_reg(RegRow1Lo, {rand_coef(), rand_coef()});
            write_reg(RegRow1Hi, {rand_coef(), rand_coef()});
            write_reg(RegRow2Lo, {rand_coef(), rand_coef()});
            write_reg(RegRow2Hi, {rand_coef(), $urandom_range(0, 3) == 0 ? 32'h0 : rand_coef()});
            random_points(60);
            drain();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: pinhole_point_projector.f
design/ppp_pkg.sv
design/ppp_if.sv
design/ppp_dot.sv
design/ppp_div_cell.sv
design/pinhole_point_projector.sv
design/ppp_checker.sv
sim/tb_pinhole_point_projector.sv
